[rtl/crba_pkg.sv]
// crba_pkg: shared types and constants for the context range best-fit allocator
// holds request/result structs, status codes, fsm states and controller/datapath links
// no dependencies
package crba_pkg;

    localparam int MAX_VFS      = 63;
    localparam int MAX_CONTEXTS = 65535;
    localparam int GRANULE      = 128;
    localparam int GRAN_SHIFT   = 7;
    localparam int GRAN_BITS    = (MAX_CONTEXTS + GRANULE - 1) / GRANULE;
    localparam int DELTA        = GRANULE - (MAX_CONTEXTS % GRANULE);

    localparam int VF_W     = 6;
    localparam int CTX_W    = 16;
    localparam int GIDX_W   = $clog2(GRAN_BITS);
    // one bit more than the index so that a count or scan position can reach GRAN_BITS
    localparam int GCNT_W   = CTX_W + 1 - GRAN_SHIFT;
    localparam int NUM_FN   = MAX_VFS + 1;
    localparam int FN_IDX_W = $clog2(NUM_FN);

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_PF_UNSUPPORTED = 2'd1,
        ST_NO_SPACE       = 2'd2
    } t_status;

    typedef struct packed {
        logic [VF_W-1:0]  vf_index;
        logic [CTX_W-1:0] requested_contexts;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [CTX_W-1:0] range_start;
        logic [CTX_W-1:0] range_count;
    } t_res;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ENTRY,
        S_LOAD,
        S_CHECK,
        S_FREE,
        S_PRIME,
        S_SCAN,
        S_DECIDE,
        S_MARK,
        S_STORE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    tbl_rd;
        logic    load_cur;
        logic    clr_step;
        logic    free_init;
        logic    free_step;
        logic    scan_prime;
        logic    scan_step;
        logic    mark_init;
        logic    mark_step;
        logic    tbl_wr;
        logic    emit;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_pf;
        logic same_quota;
        logic req_zero;
        logic walk_done;
        logic scan_last;
        logic found;
    } t_stat;

endpackage

[rtl/crba_ctrl.sv]
// crba_ctrl: sequencing state machine of the allocator
// drives crba_dp through crba_pkg::t_cmd and reads crba_pkg::t_stat back
// depends on crba_pkg
module crba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  crba_pkg::t_stat i_stat,
    output logic           busy,
    output crba_pkg::t_cmd  o_cmd
);

    crba_pkg::t_state r_state;
    crba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crba_pkg::S_CLEAR: begin
                if (i_stat.clear_last) n_state = crba_pkg::S_IDLE;
            end
            crba_pkg::S_IDLE: begin
                if (start) n_state = crba_pkg::S_ENTRY;
            end
            crba_pkg::S_ENTRY: begin
                n_state = i_stat.is_pf ? crba_pkg::S_IDLE : crba_pkg::S_LOAD;
            end
            crba_pkg::S_LOAD: begin
                n_state = crba_pkg::S_CHECK;
            end
            crba_pkg::S_CHECK: begin
                n_state = i_stat.same_quota ? crba_pkg::S_IDLE : crba_pkg::S_FREE;
            end
            crba_pkg::S_FREE: begin
                if (i_stat.walk_done) begin
                    n_state = i_stat.req_zero ? crba_pkg::S_IDLE : crba_pkg::S_PRIME;
                end
            end
            crba_pkg::S_PRIME: begin
                n_state = crba_pkg::S_SCAN;
            end
            crba_pkg::S_SCAN: begin
                if (i_stat.scan_last) n_state = crba_pkg::S_DECIDE;
            end
            crba_pkg::S_DECIDE: begin
                n_state = i_stat.found ? crba_pkg::S_MARK : crba_pkg::S_IDLE;
            end
            crba_pkg::S_MARK: begin
                if (i_stat.walk_done) n_state = crba_pkg::S_STORE;
            end
            crba_pkg::S_STORE: begin
                n_state = crba_pkg::S_IDLE;
            end
            default: begin
                n_state = crba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = crba_pkg::ST_OK;
        busy         = (r_state != crba_pkg::S_IDLE);
        unique case (r_state)
            crba_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            crba_pkg::S_IDLE: begin
                o_cmd.load = start;
            end
            crba_pkg::S_ENTRY: begin
                if (i_stat.is_pf) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = crba_pkg::ST_PF_UNSUPPORTED;
                end else begin
                    o_cmd.tbl_rd = 1'b1;
                end
            end
            crba_pkg::S_LOAD: begin
                o_cmd.load_cur = 1'b1;
            end
            crba_pkg::S_CHECK: begin
                if (i_stat.same_quota) begin
                    o_cmd.emit = 1'b1;
                end else begin
                    o_cmd.free_init = 1'b1;
                end
            end
            crba_pkg::S_FREE: begin
                if (!i_stat.walk_done) begin
                    o_cmd.free_step = 1'b1;
                end else if (i_stat.req_zero) begin
                    o_cmd.emit = 1'b1;
                end
            end
            crba_pkg::S_PRIME: begin
                o_cmd.scan_prime = 1'b1;
            end
            crba_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            crba_pkg::S_DECIDE: begin
                if (i_stat.found) begin
                    o_cmd.mark_init = 1'b1;
                end else begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = crba_pkg::ST_NO_SPACE;
                end
            end
            crba_pkg::S_MARK: begin
                o_cmd.mark_step = !i_stat.walk_done;
            end
            crba_pkg::S_STORE: begin
                o_cmd.tbl_wr = 1'b1;
                o_cmd.emit   = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[rtl/crba_dp.sv]
// crba_dp: datapath of the allocator: function range table, granule map, hole scan
// executes crba_pkg::t_cmd from crba_ctrl and reports crba_pkg::t_stat
// depends on crba_pkg
module crba_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  crba_pkg::t_req  i_req,
    input  crba_pkg::t_cmd  i_cmd,
    output crba_pkg::t_stat o_stat,
    output logic            o_done,
    output crba_pkg::t_res  o_res
);

    localparam int CW = crba_pkg::CTX_W;
    localparam int GW = crba_pkg::GCNT_W;
    localparam int IW = crba_pkg::GIDX_W;
    localparam int SH = crba_pkg::GRAN_SHIFT;

    // latched request
    logic [crba_pkg::VF_W-1:0] r_vf;
    logic [GW-1:0]             r_need;
    logic                      r_req_zero;

    // per-function range table, start in the upper half
    logic [2*CW-1:0]               r_tbl [0:crba_pkg::NUM_FN-1];
    logic [2*CW-1:0]               r_tbl_q;
    logic                          r_tbl_vq;
    logic [crba_pkg::NUM_FN-1:0]   r_valid;
    logic [CW-1:0]                 r_cur_start;
    logic [CW-1:0]                 r_cur_count;

    // granule occupancy map, 1 = used
    logic                          r_map [0:crba_pkg::GRAN_BITS-1];
    logic                          r_map_q;
    logic [GW-1:0]                 r_clr_addr;

    logic [GW-1:0]                 r_walk_addr;
    logic [GW-1:0]                 r_walk_left;

    // hole scan
    logic [GW-1:0]                 r_k;
    logic                          r_in_run;
    logic [GW-1:0]                 r_run_start;
    logic                          r_have_eq;
    logic [GW-1:0]                 r_eq_idx;
    logic                          r_have_big;
    logic [GW-1:0]                 r_big_idx;
    logic [GW-1:0]                 r_big_size;

    logic                          r_done;
    crba_pkg::t_res                r_res;

    logic [CW:0]   w_req_sum;
    logic [CW:0]   w_quota;
    logic [CW:0]   w_first_sum;
    logic [GW-1:0] w_first;
    logic [GW-1:0] w_pick;
    logic [CW-1:0] w_new_start;
    logic          w_free;
    logic [GW-1:0] w_size;
    logic          w_map_we;
    logic [IW-1:0] w_map_waddr;
    logic          w_map_wdata;
    logic          w_map_re;
    logic [IW-1:0] w_map_raddr;

    assign w_req_sum   = {1'b0, i_req.requested_contexts} + (CW+1)'(crba_pkg::GRANULE - 1);
    assign w_quota     = {r_need, {SH{1'b0}}};
    assign w_first_sum = {1'b0, r_cur_start} + (CW+1)'(crba_pkg::DELTA);
    assign w_first     = w_first_sum[CW:SH];
    assign w_pick      = r_have_eq ? r_eq_idx : r_big_idx;
    // pick*granule - delta, kept to the context width
    assign w_new_start = {w_pick[CW-SH-1:0], {SH{1'b0}}} - CW'(crba_pkg::DELTA);
    // the position one past the map reads as occupied and closes a trailing hole
    assign w_free      = (r_k < GW'(crba_pkg::GRAN_BITS)) && !r_map_q;
    assign w_size      = r_k - r_run_start;

    always_comb begin
        w_map_we    = 1'b0;
        w_map_waddr = r_walk_addr[IW-1:0];
        w_map_wdata = 1'b0;
        priority if (i_cmd.clr_step) begin
            w_map_we    = 1'b1;
            w_map_waddr = r_clr_addr[IW-1:0];
        end else if (i_cmd.free_step) begin
            w_map_we    = (r_walk_addr < GW'(crba_pkg::GRAN_BITS));
        end else if (i_cmd.mark_step) begin
            w_map_we    = (r_walk_addr < GW'(crba_pkg::GRAN_BITS));
            w_map_wdata = 1'b1;
        end else begin
            w_map_we    = 1'b0;
        end
    end

    assign w_map_re    = i_cmd.scan_prime || i_cmd.scan_step;
    assign w_map_raddr = i_cmd.scan_prime ? '0 : r_k[IW-1:0] + IW'(1);

    always_ff @(posedge i_clk) begin
        if (w_map_we) r_map[w_map_waddr] <= w_map_wdata;
        if (w_map_re) r_map_q <= r_map[w_map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr) r_tbl[r_vf] <= {r_cur_start, r_cur_count};
        if (i_cmd.tbl_rd) begin
            r_tbl_q  <= r_tbl[r_vf];
            r_tbl_vq <= r_valid[r_vf];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cmd.free_init) r_valid[r_vf] <= 1'b0;
            if (i_cmd.tbl_wr)    r_valid[r_vf] <= 1'b1;
            if (i_cmd.clr_step)  r_clr_addr <= r_clr_addr + GW'(1);
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_res <= '{status: i_cmd.status,
                                   range_start: r_cur_start,
                                   range_count: r_cur_count};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vf        <= i_req.vf_index;
            r_need      <= w_req_sum[CW:SH];
            r_req_zero  <= (i_req.requested_contexts == '0);
            r_cur_start <= '0;
            r_cur_count <= '0;
        end
        if (i_cmd.load_cur) begin
            r_cur_start <= r_tbl_vq ? r_tbl_q[2*CW-1:CW] : '0;
            r_cur_count <= r_tbl_vq ? r_tbl_q[CW-1:0]    : '0;
        end
        if (i_cmd.free_init) begin
            r_walk_addr <= w_first;
            r_walk_left <= {1'b0, r_cur_count[CW-1:SH]};
            r_cur_start <= '0;
            r_cur_count <= '0;
        end
        if (i_cmd.mark_init) begin
            r_walk_addr <= w_pick;
            r_walk_left <= r_need;
            r_cur_start <= w_new_start;
            r_cur_count <= w_quota[CW-1:0];
        end
        if (i_cmd.free_step || i_cmd.mark_step) begin
            r_walk_addr <= r_walk_addr + GW'(1);
            r_walk_left <= r_walk_left - GW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_prime) begin
            r_k        <= '0;
            r_in_run   <= 1'b0;
            r_have_eq  <= 1'b0;
            r_have_big <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_k <= r_k + GW'(1);
            if (w_free && !r_in_run) begin
                r_in_run    <= 1'b1;
                r_run_start <= r_k;
            end else if (!w_free && r_in_run) begin
                r_in_run <= 1'b0;
                if (w_size == r_need) begin
                    // exact fit, but never the hole at the map's start
                    if (r_run_start != '0) begin
                        r_have_eq <= 1'b1;
                        r_eq_idx  <= r_run_start;
                    end
                end else if (w_size > r_need && (!r_have_big || w_size < r_big_size)) begin
                    r_have_big <= 1'b1;
                    r_big_size <= w_size;
                    r_big_idx  <= r_k - r_need;
                end
            end
        end
    end

    always_comb begin
        o_stat.clear_last = (r_clr_addr == GW'(crba_pkg::GRAN_BITS - 1));
        o_stat.is_pf      = (r_vf == '0) ||
                            ({1'b0, r_vf} > (crba_pkg::VF_W+1)'(crba_pkg::MAX_VFS));
        o_stat.same_quota = (w_quota == {1'b0, r_cur_count});
        o_stat.req_zero   = r_req_zero;
        o_stat.walk_done  = (r_walk_left == '0);
        o_stat.scan_last  = (r_k == GW'(crba_pkg::GRAN_BITS));
        o_stat.found      = r_have_eq || r_have_big;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[rtl/context_range_best_fit_allocator_unit.sv]
// context_range_best_fit_allocator_unit: top level of the context range allocator
// instantiates crba_ctrl and crba_dp, uses types from crba_pkg
//
// usage: drive i_req (function index, contexts wanted) and raise start while busy
// is low; the request is taken at that edge and busy rises the next cycle.
// exactly one result per request appears on o_res for a single cycle with o_done
// high; busy is already low in that cycle. the receiver cannot hold results off.
// how long a request takes depends on the work done:
//   physical function refused:          answered after the function check
//   quota unchanged:                    answered after the table read
//   release only (zero contexts):       frees the old range's granules
//   new range:                          frees, scans the map, marks granules
// the hole scan walks all 512 granule bits of the map memory, one per cycle,
// and the free and mark walks write that memory one granule per cycle; these
// dominate the time that a request takes.
// after reset the block clears the 512-entry granule map, one entry a cycle,
// holding busy high until the clear is done; no request is taken before that.
// the function table starts empty (per-entry valid bits cleared by reset).
module context_range_best_fit_allocator_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  crba_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output crba_pkg::t_res o_res
);

    crba_pkg::t_cmd  w_cmd;
    crba_pkg::t_stat w_stat;

    crba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    crba_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // a result only follows a cycle in which a request was in flight
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without request in flight");

    // a taken request makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // a result frees the block for the next request
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy still high when result shown");

    // refusals and failures carry no range
    a_fail_no_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != crba_pkg::ST_OK) |->
            (o_res.range_start == '0 && o_res.range_count == '0))
        else $error("failed request reports a range");

endmodule

[sim/context_range_best_fit_allocator_unit_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for context_range_best_fit_allocator_unit: directed and random requests
// checked against typed expectations or an in-bench best-fit model; depends on crba_pkg and the rtl top level
module context_range_best_fit_allocator_unit_test;
    import crba_pkg::*;

    localparam int RANDOM_REQUESTS = 550;
    // run bound: the worst request plus a sender gap, for every request and several times over
    localparam int LIMIT_CYCLES    = 4_000_000;
    localparam int DRAIN_CYCLES    = 2000;

    typedef struct {
        t_req    req;
        bit      typed;
        t_res    want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_res o_res;

    // model state: range per function and the granule occupancy map
    logic [CTX_W-1:0] fn_start [NUM_FN];
    logic [CTX_W-1:0] fn_count [NUM_FN];
    bit               granule_used [GRAN_BITS];

    t_res      awaited_results [$];
    t_stim_row directed_rows [$];

    int unsigned cycle_cnt;
    int unsigned fail_cnt;
    int unsigned sent_cnt;
    int unsigned ok_cnt;
    int unsigned no_space_cnt;
    int unsigned refused_cnt;

    context_range_best_fit_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_res predict_allocation(t_req r);
        t_res        res;
        int unsigned fn, req, need, quota, k, first, run_start, size, pick;
        int unsigned eq_at, big_at, big_size;
        bit          in_run, have_eq, have_big, free_bit;
        res.status      = ST_OK;
        res.range_start = '0;
        res.range_count = '0;
        fn  = r.vf_index;
        req = r.requested_contexts;
        if (fn == 0 || fn > MAX_VFS) begin
            res.status = ST_PF_UNSUPPORTED;
            return res;
        end
        need  = (req + GRANULE - 1) / GRANULE;
        quota = need * GRANULE;
        if (quota != fn_count[fn]) begin
            // give back whatever the function held
            if (fn_count[fn] != 0) begin
                first = (int'(fn_start[fn]) + DELTA) / GRANULE;
                for (k = first; k < first + fn_count[fn] / GRANULE; k++)
                    if (k < GRAN_BITS) granule_used[k] = 1'b0;
            end
            fn_start[fn] = '0;
            fn_count[fn] = '0;
            if (req != 0) begin
                in_run    = 1'b0;
                have_eq   = 1'b0;
                have_big  = 1'b0;
                run_start = 0;
                eq_at     = 0;
                big_at    = 0;
                big_size  = 0;
                for (k = 0; k <= GRAN_BITS; k++) begin
                    free_bit = (k < GRAN_BITS) && !granule_used[k];
                    if (free_bit && !in_run) begin
                        in_run    = 1'b1;
                        run_start = k;
                    end else if (!free_bit && in_run) begin
                        in_run = 1'b0;
                        size   = k - run_start;
                        if (size == need) begin
                            // an exact hole at granule 0 is never taken
                            if (run_start != 0) begin
                                have_eq = 1'b1;
                                eq_at   = run_start;
                            end
                        end else if (size > need && (!have_big || size < big_size)) begin
                            have_big = 1'b1;
                            big_size = size;
                            big_at   = k - need;
                        end
                    end
                end
                if (!have_eq && !have_big) begin
                    res.status = ST_NO_SPACE;
                    return res;
                end
                pick = have_eq ? eq_at : big_at;
                for (k = pick; k < pick + need; k++)
                    if (k < GRAN_BITS) granule_used[k] = 1'b1;
                fn_start[fn] = CTX_W'(pick * GRANULE - DELTA);
                fn_count[fn] = CTX_W'(quota);
            end
        end
        res.range_start = fn_start[fn];
        res.range_count = fn_count[fn];
        return res;
    endfunction

    function automatic t_stim_row mk_row(int vf, int req, bit typed = 1'b0,
                                         t_status st = ST_OK, int s = 0, int c = 0);
        t_stim_row row;
        row.req.vf_index           = vf[VF_W-1:0];
        row.req.requested_contexts = req[CTX_W-1:0];
        row.typed                  = typed;
        row.want.status            = st;
        row.want.range_start       = s[CTX_W-1:0];
        row.want.range_count       = c[CTX_W-1:0];
        return row;
    endfunction

    // mostly plausible provisioning traffic on a few functions, with some noise
    function automatic t_req draw_request();
        t_req        r;
        int unsigned sel;
        int unsigned cur;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            r.vf_index = '0;
        else if ($urandom_range(0, 3) == 0)
            r.vf_index = VF_W'($urandom_range(1, MAX_VFS));
        else
            r.vf_index = VF_W'($urandom_range(1, 12));
        cur = fn_count[r.vf_index];
        sel = $urandom_range(0, 99);
        if (sel < 20)
            r.requested_contexts = '0;
        else if (sel < 35)
            // same quota, possibly unaligned
            r.requested_contexts = (cur == 0) ? '0 : CTX_W'(cur - $urandom_range(0, GRANULE - 1));
        else if (sel < 70)
            r.requested_contexts = CTX_W'($urandom_range(1, 2048));
        else if (sel < 90)
            r.requested_contexts = CTX_W'($urandom_range(1, 16384));
        else
            r.requested_contexts = CTX_W'($urandom_range(0, 65535));
        return r;
    endfunction

    task automatic issue(input t_req r, input bit typed, input t_res want);
        t_res model;
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        model = predict_allocation(r);
        awaited_results.push_back(typed ? want : model);
        sent_cnt++;
    endtask

    task automatic pause(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d start %0d count %0d",
                       o_res.status, o_res.range_start, o_res.range_count);
                fail_cnt++;
            end else begin
                exp_res = awaited_results.pop_front();
                if (o_res.status != exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_res.status);
                    fail_cnt++;
                end
                if (o_res.range_start != exp_res.range_start) begin
                    $error("range_start: expected %0d, got %0d",
                           exp_res.range_start, o_res.range_start);
                    fail_cnt++;
                end
                if (o_res.range_count != exp_res.range_count) begin
                    $error("range_count: expected %0d, got %0d",
                           exp_res.range_count, o_res.range_count);
                    fail_cnt++;
                end
                case (exp_res.status)
                    ST_OK:             ok_cnt++;
                    ST_NO_SPACE:       no_space_cnt++;
                    default:           refused_cnt++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, awaited_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned i, burst, gap;
        t_res        none;
        sent_cnt     = 0;
        none         = '0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        for (i = 0; i < NUM_FN; i++) begin
            fn_start[i] = '0;
            fn_count[i] = '0;
        end
        for (i = 0; i < GRAN_BITS; i++) granule_used[i] = 1'b0;

        directed_rows = '{
            mk_row(0, 100, 1'b1, ST_PF_UNSUPPORTED, 0, 0),
            mk_row(0, 0, 1'b1, ST_PF_UNSUPPORTED, 0, 0),
            mk_row(63, 0, 1'b1, ST_OK, 0, 0),
            // first range lands at the top of the empty map
            mk_row(1, 1, 1'b1, ST_OK, 65407, 128),
            mk_row(1, 128, 1'b1, ST_OK, 65407, 128),
            // a full map's worth never fits: the only hole starts at granule 0
            mk_row(2, 65535, 1'b1, ST_NO_SPACE, 0, 0),
            mk_row(1, 0, 1'b1, ST_OK, 0, 0),
            mk_row(3, 65408, 1'b1, ST_OK, 127, 65408),
            mk_row(4, 1, 1'b1, ST_NO_SPACE, 0, 0),
            mk_row(5, 129),
            mk_row(3, 65280),
            mk_row(3, 0, 1'b1, ST_OK, 0, 0),
            mk_row(10, 512),
            mk_row(11, 512),
            mk_row(12, 512),
            mk_row(11, 0),
            // exact fit into the freed hole
            mk_row(13, 512),
            mk_row(12, 0),
            mk_row(10, 0),
            // an exact hole at the top wins over the large one below
            mk_row(14, 500),
            // smallest larger hole, placed at its end
            mk_row(15, 200),
            mk_row(42, 32767),
            mk_row(21, 32769),
            mk_row(63, 65535, 1'b1, ST_NO_SPACE, 0, 0),
            mk_row(63, 65409)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            issue(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);
            gap = $urandom_range(0, 3);
            if (gap != 0) pause(gap);
        end

        i = 0;
        while (i < RANDOM_REQUESTS) begin
            burst = $urandom_range(1, 8);
            while (burst != 0 && i < RANDOM_REQUESTS) begin
                issue(draw_request(), 1'b0, none);
                burst--;
                i++;
            end
            // some bursts run straight into the next one
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 30));
        end
        start <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests in %0d cycles: %0d placed or released, %0d without space,",
                 sent_cnt, cycle_cnt, ok_cnt, no_space_cnt);
        $display("%0d refused for the physical function", refused_cnt);
        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
